>>> rtl/core/tss_pkg.sv
// Shared types and constants for the timed step sequencer.
// Holds the channel payload structs, the function and result codes, and the
// control/status structs between the controller and the datapath.
package tss_pkg;

	localparam int STEP_W = 16;
	localparam int ID_W   = 8;
	localparam int TICK_W = STEP_W + 1;
	localparam int ENT_W  = STEP_W + ID_W;

	// function codes
	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_START  = 2'd1;
	localparam logic [1:0] FN_TICK   = 2'd2;

	// result kinds
	localparam logic [2:0] K_INSERTED = 3'd0;
	localparam logic [2:0] K_FULL     = 3'd1;
	localparam logic [2:0] K_BUSY     = 3'd2;
	localparam logic [2:0] K_STARTED  = 3'd3;
	localparam logic [2:0] K_EMPTY    = 3'd4;
	localparam logic [2:0] K_FIRE     = 3'd5;
	localparam logic [2:0] K_DONE     = 3'd6;
	localparam logic [2:0] K_NOTHING  = 3'd7;

	typedef struct packed {
		logic [1:0]        func;
		logic [STEP_W-1:0] step;
		logic [ID_W-1:0]   action_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [ID_W-1:0]   fired_id;
		logic [STEP_W-1:0] fired_step;
		logic              last;
	} res_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;      // capture incoming transaction
		logic       emit;      // load the result register
		logic [2:0] kind;
		logic       fire;      // result fields come from the pending entry
		logic       last;
		logic       rd_ins;    // read port follows the insert index
		logic       idx_load;
		logic       idx_dec;
		logic       ram_we;
		logic       wr_new;    // write the new entry, else move the read entry up
		logic       count_inc;
		logic       start;
		logic       stop;
		logic       next_inc;
		logic       tick_inc;
		logic       pend_load;
		logic       pend_clr;
	} dp_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] func;
		logic       running;
		logic       full;
		logic       empty;
		logic       ins_stop;
		logic       match;
		logic       next_end;
		logic       pend_v;
		logic       out_free;
	} dp_sts_t;

endpackage

>>> rtl/core/tss_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tss_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/tss_datapath.sv
// Datapath of the timed step sequencer: entry table RAM, counters, pending
// fire entry and result register. Uses tss_pkg and tss_ram.
module tss_datapath #(
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tss_pkg::cmd_t   cmd,
	input  tss_pkg::dp_ctl_t ctl,
	output tss_pkg::dp_sts_t sts,
	output tss_pkg::res_t   res,
	output logic            res_valid,
	input  logic            res_stall
);

	import tss_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t              in_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     idx_d;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     next_q;
	logic [CW-1:0]     next_d;
	logic [TICK_W-1:0] tick_q;
	logic              running_q;
	logic              pend_v_q;
	logic [STEP_W-1:0] pend_step_q;
	logic [ID_W-1:0]   pend_id_q;
	res_t              res_q;
	logic              res_valid_q;

	logic [AW-1:0]     raddr;
	logic [ENT_W-1:0]  rdata;
	logic [ENT_W-1:0]  wdata;
	logic [STEP_W-1:0] rd_step;
	logic [ID_W-1:0]   rd_id;

	assign rd_step = rdata[ENT_W-1:ID_W];
	assign rd_id   = rdata[ID_W-1:0];

	always_comb begin
		if (ctl.idx_load) begin
			idx_d = count_q[AW-1:0];
		end else if (ctl.idx_dec) begin
			idx_d = idx_q - 1'b1;
		end else begin
			idx_d = idx_q;
		end
		if (ctl.start) begin
			next_d = '0;
		end else if (ctl.next_inc) begin
			next_d = next_q + 1'b1;
		end else begin
			next_d = next_q;
		end
	end

	// read address tracks next-cycle indexes so rdata is current when needed
	assign raddr = ctl.rd_ins ? idx_d - 1'b1 : next_d[AW-1:0];
	assign wdata = ctl.wr_new ? {in_q.step, in_q.action_id} : rdata;

	tss_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (ctl.ram_we),
		.waddr(idx_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		sts.func     = in_q.func;
		sts.running  = running_q;
		sts.full     = (count_q == CW'(DEPTH));
		sts.empty    = (count_q == '0);
		sts.ins_stop = (idx_q == '0) || (rd_step <= in_q.step);
		sts.next_end = (next_q >= count_q);
		sts.match    = !sts.next_end && (tick_q == {1'b0, rd_step});
		sts.pend_v   = pend_v_q;
		sts.out_free = !res_valid_q || !res_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			next_q      <= '0;
			tick_q      <= '0;
			running_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			next_q <= next_d;
			if (ctl.count_inc) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.start) begin
				tick_q <= '0;
			end else if (ctl.tick_inc) begin
				tick_q <= tick_q + 1'b1;
			end
			if (ctl.start) begin
				running_q <= 1'b1;
			end else if (ctl.stop) begin
				running_q <= 1'b0;
			end
			if (ctl.pend_load) begin
				pend_v_q <= 1'b1;
			end else if (ctl.pend_clr) begin
				pend_v_q <= 1'b0;
			end
			if (ctl.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			in_q <= cmd;
		end
		idx_q <= idx_d;
		if (ctl.pend_load) begin
			pend_step_q <= rd_step;
			pend_id_q   <= rd_id;
		end
		if (ctl.emit) begin
			res_q.kind       <= ctl.kind;
			res_q.fired_id   <= ctl.fire ? pend_id_q : '0;
			res_q.fired_step <= ctl.fire ? pend_step_q : '0;
			res_q.last       <= ctl.last;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

>>> rtl/core/tss_ctrl.sv
// Controller state machine of the timed step sequencer.
// Uses tss_pkg; drives the datapath through dp_ctl_t and reads dp_sts_t.
module tss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  tss_pkg::dp_sts_t sts,
	output tss_pkg::dp_ctl_t ctl
);

	import tss_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_FIRE = 3'd3;
	localparam logic [2:0] S_END  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.rd_ins = (sts.func == FN_INSERT);
				case (sts.func)
					FN_INSERT: begin
						if (sts.running || sts.full) begin
							if (sts.out_free) begin
								ctl.emit = 1'b1;
								ctl.kind = sts.running ? K_BUSY : K_FULL;
								ctl.last = 1'b1;
								state_d  = S_IDLE;
							end
						end else begin
							ctl.idx_load = 1'b1;
							state_d      = S_INS;
						end
					end
					FN_START: begin
						if (sts.out_free) begin
							ctl.emit  = 1'b1;
							ctl.last  = 1'b1;
							ctl.kind  = sts.empty ? K_EMPTY : K_STARTED;
							ctl.start = !sts.empty;
							state_d   = S_IDLE;
						end
					end
					FN_TICK: begin
						if (sts.running) begin
							state_d = S_FIRE;
						end else if (sts.out_free) begin
							ctl.emit = 1'b1;
							ctl.kind = K_NOTHING;
							ctl.last = 1'b1;
							state_d  = S_IDLE;
						end
					end
					default: begin
						if (sts.out_free) begin
							ctl.emit = 1'b1;
							ctl.kind = K_NOTHING;
							ctl.last = 1'b1;
							state_d  = S_IDLE;
						end
					end
				endcase
			end
			S_INS: begin
				// walk down from the end, moving larger steps up one slot
				ctl.rd_ins = 1'b1;
				if (sts.ins_stop) begin
					if (sts.out_free) begin
						ctl.ram_we    = 1'b1;
						ctl.wr_new    = 1'b1;
						ctl.count_inc = 1'b1;
						ctl.emit      = 1'b1;
						ctl.kind      = K_INSERTED;
						ctl.last      = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					ctl.ram_we  = 1'b1;
					ctl.idx_dec = 1'b1;
				end
			end
			S_FIRE: begin
				// a fired entry is held back one entry so its last flag is known
				if (sts.match) begin
					if (!sts.pend_v || sts.out_free) begin
						ctl.emit      = sts.pend_v;
						ctl.kind      = K_FIRE;
						ctl.fire      = 1'b1;
						ctl.pend_load = 1'b1;
						ctl.next_inc  = 1'b1;
					end
				end else begin
					state_d = S_END;
				end
			end
			S_END: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					if (sts.pend_v) begin
						ctl.kind     = K_FIRE;
						ctl.fire     = 1'b1;
						ctl.pend_clr = 1'b1;
						ctl.last     = !sts.next_end;
						if (!sts.next_end) begin
							ctl.tick_inc = 1'b1;
							state_d      = S_IDLE;
						end
					end else begin
						ctl.kind     = sts.next_end ? K_DONE : K_NOTHING;
						ctl.stop     = sts.next_end;
						ctl.last     = 1'b1;
						ctl.tick_inc = 1'b1;
						state_d      = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/timed_step_sequencer.sv
// Timed step sequencer: a table of up to DEPTH (step, action) entries kept in
// step order, played back one tick at a time. One transaction is handled at a
// time. An accepted insert walks down from the end of the table, moving each
// entry with a higher step up one slot (fewer than DEPTH move), one RAM read
// and write per cycle. A tick while running reads the table once per fired
// entry, and a done result follows the last fire when it ends the table. A
// refused insert, a tick while idle, start and the other codes give a single
// result. A waiting result does not hold off the next transaction, but a new
// result waits for the result register to drain. The table has no reset;
// entries beyond the fill count may be read but their data is never used.
module timed_step_sequencer #(
	parameter int DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tss_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output tss_pkg::res_t res
);

	import tss_pkg::*;

	dp_ctl_t ctl;
	dp_sts_t sts;

	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	tss_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.ctl      (ctl),
		.sts      (sts),
		.res      (res),
		.res_valid(res_valid),
		.res_stall(res_stall)
	);

endmodule
